// ----- sv/tse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the exhaustive tour search unit.
// Depends on nothing; every other file imports it.
package tse_pkg;

    // Default number of cities the matrix is built for.
    localparam int MAX_CITIES_DEF = 8;

    // Field widths fixed by the interface.
    localparam int CITY_W   = 4;
    localparam int INDEX_W  = 3;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 19;
    localparam logic [COST_W-1:0] COST_MAX = 19'h7FFFF;

    // Smallest tour the search accepts.
    localparam logic [CITY_W-1:0] MIN_CITIES = 4'd3;

    // Input word modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // Configuration port geometry and register indexes.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CITY_COUNT = 1'b0;
    localparam logic REG_START_CITY = 1'b1;
    localparam logic [CITY_W-1:0] CITY_COUNT_RST = 4'd8;
    localparam logic [CITY_W-1:0] START_CITY_RST = 4'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_START,
        ST_SUM_ISSUE,
        ST_SUM_DRAIN,
        ST_COMPARE,
        ST_PIVOT,
        ST_PIV_READ,
        ST_SW_FIND,
        ST_SWAP,
        ST_REV_CHECK,
        ST_REV_READ,
        ST_REV_WRITE,
        ST_EMIT
    } tse_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mem_wr;
        logic init;
        logic sum_start;
        logic sum_issue;
        logic compare;
        logic piv_load;
        logic piv_read;
        logic sw_find;
        logic swap;
        logic rev_read;
        logic rev_write;
        logic emit_clear;
        logic emit_next;
    } tse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_last;
        logic piv_found;
        logic rev_more;
        logic emit_last;
    } tse_stat_t;

endpackage

// ----- sv/tse_controller.sv -----
`timescale 1ns / 1ps
// Sequencer of the tour search: loads, tour cost sums, next permutation and result words.
// Depends on tse_pkg for the state type and the command and status structs.
module tse_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tse_pkg::tse_stat_t   stat,
    output tse_pkg::tse_cmd_t    cmd
);
    import tse_pkg::*;

    tse_state_t state_reg;
    tse_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_RUN)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_SUM_START;
                    end
                    else
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                end
            end
            ST_SUM_START:
            begin
                cmd.sum_start = 1'b1;
                state_next    = ST_SUM_ISSUE;
            end
            ST_SUM_ISSUE:
            begin
                cmd.sum_issue = 1'b1;
                if (stat.sum_last)
                begin
                    state_next = ST_SUM_DRAIN;
                end
            end
            ST_SUM_DRAIN:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_PIVOT;
            end
            ST_PIVOT:
            begin
                cmd.piv_load = 1'b1;
                if (stat.piv_found)
                begin
                    state_next = ST_PIV_READ;
                end
                else
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_PIV_READ:
            begin
                cmd.piv_read = 1'b1;
                state_next   = ST_SW_FIND;
            end
            ST_SW_FIND:
            begin
                cmd.sw_find = 1'b1;
                state_next  = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_REV_CHECK;
            end
            ST_REV_CHECK:
            begin
                state_next = stat.rev_more ? ST_REV_READ : ST_SUM_START;
            end
            ST_REV_READ:
            begin
                cmd.rev_read = 1'b1;
                state_next   = ST_REV_WRITE;
            end
            ST_REV_WRITE:
            begin
                cmd.rev_write = 1'b1;
                state_next    = ST_REV_CHECK;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result word is never offered while an input word can be taken.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

endmodule

// ----- sv/tse_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the tour search: weight memory, current and best tour, cost accumulator.
// Depends on tse_pkg for widths and the command and status structs.
module tse_datapath #(
    parameter int MAX_CITIES = tse_pkg::MAX_CITIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tse_pkg::tse_cmd_t                cmd,
    output tse_pkg::tse_stat_t               stat,
    input  logic [tse_pkg::CITY_W-1:0]       n_city,
    input  logic [tse_pkg::CITY_W-1:0]       s_city,
    input  logic [tse_pkg::INDEX_W-1:0]      from_city,
    input  logic [tse_pkg::INDEX_W-1:0]      to_city,
    input  logic [tse_pkg::WEIGHT_W-1:0]     weight,
    output logic [tse_pkg::CITY_W-1:0]       tour_city,
    output logic [tse_pkg::COST_W-1:0]       tour_cost,
    output logic                             last
);
    import tse_pkg::*;

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_CITIES + 1);

    // Weight memory, row-major, with a registered read port.
    logic [WEIGHT_W-1:0] mem [0:DEPTH-1];
    logic [WEIGHT_W-1:0] mem_q_reg;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic                wr_ok;

    // Tours and search registers.
    logic [CITY_W-1:0] tour_reg      [0:MAX_CITIES];
    logic [CITY_W-1:0] tour_next     [0:MAX_CITIES];
    logic [CITY_W-1:0] best_tour_reg [0:MAX_CITIES];
    logic [CITY_W-1:0] best_tour_next[0:MAX_CITIES];
    logic [COST_W-1:0] best_cost_reg, best_cost_next;
    logic [COST_W-1:0] acc_reg, acc_next;
    logic [CITY_W-1:0] prev_reg, prev_next;
    logic [CITY_W-1:0] tmp_reg, tmp_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [IW-1:0]     n_reg, n_next;
    logic [IW-1:0]     piv_reg, piv_next;
    logic [IW-1:0]     sw_reg, sw_next;
    logic [IW-1:0]     lo_reg, lo_next;
    logic [IW-1:0]     hi_reg, hi_next;
    logic              first_reg, first_next;
    logic              vld_reg, vld_next;

    logic [IW-1:0]     rd_idx;
    logic [CITY_W-1:0] rd_data;
    logic [IW-1:0]     piv_idx;
    logic              piv_found;
    logic [IW-1:0]     sw_idx;
    logic [COST_W:0]   sum_w;

    // Single read port on the current tour.
    always_comb
    begin
        if (cmd.sum_issue)
        begin
            rd_idx = k_reg;
        end
        else if (cmd.piv_read)
        begin
            rd_idx = piv_reg;
        end
        else if (cmd.swap)
        begin
            rd_idx = sw_reg;
        end
        else if (cmd.rev_read)
        begin
            rd_idx = lo_reg;
        end
        else if (cmd.rev_write)
        begin
            rd_idx = hi_reg;
        end
        else
        begin
            rd_idx = k_reg;
        end
    end
    assign rd_data = tour_reg[rd_idx];

    // Memory addresses: the load word, and the edge from the previous city to this one.
    assign wr_ok   = (int'(from_city) < MAX_CITIES) && (int'(to_city) < MAX_CITIES);
    assign wr_addr = AW'(int'(from_city) * MAX_CITIES + int'(to_city));
    assign rd_addr = AW'((int'(prev_reg) - 1) * MAX_CITIES + int'(rd_data) - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_ok)
        begin
            mem[wr_addr] <= weight;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Pivot: the highest inner position whose city is below its right neighbor.
    always_comb
    begin
        piv_idx   = '0;
        piv_found = 1'b0;
        for (int i = 1; i < MAX_CITIES - 1; i++)
        begin
            if ((i + 1 < int'(n_reg)) && (tour_reg[i] < tour_reg[i + 1]))
            begin
                piv_idx   = IW'(i);
                piv_found = 1'b1;
            end
        end
    end

    // Swap partner: the last position after the pivot holding a larger city.
    always_comb
    begin
        sw_idx = '0;
        for (int j = 1; j < MAX_CITIES; j++)
        begin
            if ((j > int'(piv_reg)) && (j < int'(n_reg)) && (tour_reg[j] > tmp_reg))
            begin
                sw_idx = IW'(j);
            end
        end
    end

    // Saturating edge accumulation.
    assign sum_w = {1'b0, acc_reg} + (COST_W + 1)'(mem_q_reg);

    // Next values of the datapath registers.
    always_comb
    begin
        tour_next      = tour_reg;
        best_tour_next = best_tour_reg;
        best_cost_next = best_cost_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        tmp_next       = tmp_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        piv_next       = piv_reg;
        sw_next        = sw_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        vld_next       = cmd.sum_issue;

        if (vld_reg)
        begin
            acc_next = sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];
        end

        // Ascending tour of the inner cities, start city at both ends.
        if (cmd.init)
        begin
            n_next     = IW'(n_city);
            first_next = 1'b1;
            for (int p = 0; p <= MAX_CITIES; p++)
            begin
                if ((p == 0) || (p >= int'(n_city)))
                begin
                    tour_next[p] = s_city;
                end
                else if (p < int'(s_city))
                begin
                    tour_next[p] = CITY_W'(p);
                end
                else
                begin
                    tour_next[p] = CITY_W'(p + 1);
                end
            end
        end

        if (cmd.sum_start)
        begin
            k_next    = IW'(1);
            prev_next = tour_reg[0];
            acc_next  = '0;
        end

        if (cmd.sum_issue)
        begin
            prev_next = rd_data;
            k_next    = IW'(k_reg + 1'b1);
        end

        // Keep the first strictly cheapest tour.
        if (cmd.compare)
        begin
            first_next = 1'b0;
            if (first_reg || (acc_reg < best_cost_reg))
            begin
                best_cost_next = acc_reg;
                best_tour_next = tour_reg;
            end
        end

        if (cmd.piv_load)
        begin
            piv_next = piv_idx;
        end

        if (cmd.piv_read || cmd.rev_read)
        begin
            tmp_next = rd_data;
        end

        if (cmd.sw_find)
        begin
            sw_next = sw_idx;
        end

        if (cmd.swap)
        begin
            tour_next[piv_reg] = rd_data;
            tour_next[sw_reg]  = tmp_reg;
            lo_next            = IW'(piv_reg + 1'b1);
            hi_next            = IW'(n_reg - 1'b1);
        end

        // Tail reversal, one pair at a time: swap the pair at lo and hi and move both inward.
        if (cmd.rev_write)
        begin
            tour_next[lo_reg] = rd_data;
            tour_next[hi_reg] = tmp_reg;
            lo_next           = IW'(lo_reg + 1'b1);
            hi_next           = IW'(hi_reg - 1'b1);
        end

        if (cmd.emit_clear)
        begin
            k_next = '0;
        end
        if (cmd.emit_next)
        begin
            k_next = IW'(k_reg + 1'b1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            first_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            first_reg <= first_next;
            vld_reg   <= vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tour_reg      <= tour_next;
        best_tour_reg <= best_tour_next;
        best_cost_reg <= best_cost_next;
        acc_reg       <= acc_next;
        prev_reg      <= prev_next;
        tmp_reg       <= tmp_next;
        n_reg         <= n_next;
        piv_reg       <= piv_next;
        sw_reg        <= sw_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
    end

    // Status to the controller.
    always_comb
    begin
        stat.sum_last  = (k_reg == n_reg);
        stat.piv_found = piv_found;
        stat.rev_more  = (lo_reg < hi_reg);
        stat.emit_last = (k_reg == n_reg);
    end

    // Result word.
    assign tour_city = best_tour_reg[k_reg];
    assign tour_cost = best_cost_reg;
    assign last      = (k_reg == n_reg);

    // The swap partner always lies right of the pivot.
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap |-> (sw_reg > piv_reg))
        else $error("swap partner not right of pivot");

    // A reversal step only runs on a pair that has not crossed.
    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rev_write |-> (lo_reg < hi_reg))
        else $error("tail reversal past its midpoint");

    // The result index advances only before the return to start.
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_next |=> (k_reg <= n_reg) && !cmd.emit_clear)
        else $error("result index ran past the tour");

endmodule

// ----- sv/tsp_exhaustive_search_unit.sv -----
`timescale 1ns / 1ps
// Exhaustive tour search. A load word writes one weight and gives no result.
// A run word sums each tour through the weight memory read port, then forms the next
// permutation with up to (n-2)/2 tail swaps; it tries all (n-1)! orders of the inner
// cities, followed by n+1 result words, one per cycle when taken.
// Reset clears the sequencer and sets city_count to 8 and start_city to 1; weights hold
// no value until written.
module tsp_exhaustive_search_unit #(
    parameter int MAX_CITIES = tse_pkg::MAX_CITIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tse_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tse_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tse_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [tse_pkg::INDEX_W-1:0]      from_city,
    input  logic [tse_pkg::INDEX_W-1:0]      to_city,
    input  logic [tse_pkg::WEIGHT_W-1:0]     weight,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tse_pkg::CITY_W-1:0]       tour_city,
    output logic [tse_pkg::COST_W-1:0]       tour_cost,
    output logic                             last
);
    import tse_pkg::*;

    logic [CITY_W-1:0] city_count_reg;
    logic [CITY_W-1:0] start_city_reg;
    logic [CITY_W-1:0] n_eff;
    logic [CITY_W-1:0] s_eff;
    logic              reg_idx;
    logic              cfg_wr;
    tse_cmd_t          cmd;
    tse_stat_t         stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_COUNT_RST;
            start_city_reg <= START_CITY_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_CITY_COUNT: city_count_reg <= pwdata[CITY_W-1:0];
                REG_START_CITY: start_city_reg <= pwdata[CITY_W-1:0];
                default:        city_count_reg <= city_count_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (reg_idx)
            REG_CITY_COUNT: prdata = APB_DATA_W'(city_count_reg);
            REG_START_CITY: prdata = APB_DATA_W'(start_city_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp the city count between MIN_CITIES and the build size and the start city into the tour.
    always_comb
    begin
        if (city_count_reg < MIN_CITIES)
        begin
            n_eff = MIN_CITIES;
        end
        else if (int'(city_count_reg) > MAX_CITIES)
        begin
            n_eff = CITY_W'(MAX_CITIES);
        end
        else
        begin
            n_eff = city_count_reg;
        end

        if (start_city_reg == '0)
        begin
            s_eff = CITY_W'(1);
        end
        else if (start_city_reg > n_eff)
        begin
            s_eff = n_eff;
        end
        else
        begin
            s_eff = start_city_reg;
        end
    end

    tse_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tse_datapath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .n_city    (n_eff),
        .s_city    (s_eff),
        .from_city (from_city),
        .to_city   (to_city),
        .weight    (weight),
        .tour_city (tour_city),
        .tour_cost (tour_cost),
        .last      (last)
    );

endmodule

// ----- dv/tsp_exhaustive_search_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the exhaustive tour search unit: loads weights, runs searches
// under several city settings and checks every tour word against its own search model.
// Depends on tse_pkg and tsp_exhaustive_search_unit.
module tsp_exhaustive_search_unit_tb;
    import tse_pkg::*;

    localparam int MAX_CITIES    = MAX_CITIES_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [APB_ADDR_W-1:0] ADDR_CITY_COUNT = {REG_CITY_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_START_CITY = {REG_START_CITY, 2'b00};

    // One input word plus the idle cycles the sender spends before offering it.
    typedef struct {
        logic                mode;
        logic [INDEX_W-1:0]  from_city;
        logic [INDEX_W-1:0]  to_city;
        logic [WEIGHT_W-1:0] weight;
        int                  gap;
    } word_t;

    // One predicted word of the cheapest tour.
    typedef struct {
        logic [CITY_W-1:0] city;
        logic [COST_W-1:0] cost;
        logic              last;
    } tour_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = MODE_LOAD;
    logic [INDEX_W-1:0]    from_city = '0;
    logic [INDEX_W-1:0]    to_city = '0;
    logic [WEIGHT_W-1:0]   weight = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CITY_W-1:0]     tour_city;
    logic [COST_W-1:0]     tour_cost;
    logic                  last;

    // Stimulus and scoreboard state.
    word_t      word_queue[$];
    word_t      cur_word;
    tour_word_t tour_words_due[$];
    logic [WEIGHT_W-1:0] weight_mirror[0:MAX_CITIES-1][0:MAX_CITIES-1];
    bit         loaded[0:MAX_CITIES-1][0:MAX_CITIES-1];
    logic [CITY_W-1:0] cfg_city_count = CITY_COUNT_RST;
    logic [CITY_W-1:0] cfg_start_city = START_CITY_RST;
    int         stim_cities = MAX_CITIES;
    int         send_gap_max = 9;
    int         recv_stall_max = 9;
    int         words_queued = 0;
    int         words_accepted = 0;
    int         search_count = 0;
    int         tour_words_checked = 0;
    int         error_count = 0;
    bit         word_taken = 1'b0;
    bit         tour_taken = 1'b0;
    bit         hold_request = 1'b0;
    int         hold_count = 0;
    logic       long_hold = 1'b0;
    int         stall_left = 0;

    tsp_exhaustive_search_unit #(
        .MAX_CITIES(MAX_CITIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .from_city (from_city),
        .to_city   (to_city),
        .weight    (weight),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tour_city (tour_city),
        .tour_cost (tour_cost),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Clamp a city count register value to the range the search supports.
    function automatic int eff_cities(input logic [CITY_W-1:0] count);
        if (count < MIN_CITIES)
            return int'(MIN_CITIES);
        if (int'(count) > MAX_CITIES)
            return MAX_CITIES;
        return int'(count);
    endfunction

    // Cost of a closed tour, saturated to the cost width.
    function automatic int tour_length(input int t[0:MAX_CITIES], input int n);
        int k;
        int sum;
        sum = 0;
        for (k = 0; k < n; k++)
            sum += int'(weight_mirror[t[k]-1][t[k+1]-1]);
        return (sum > int'(COST_MAX)) ? int'(COST_MAX) : sum;
    endfunction

    // Apply one accepted word: a load updates the weight mirror, a run walks every
    // permutation of the inner cities and queues the cheapest tour found first.
    function automatic void predict_best_tour(input word_t w);
        int n;
        int s;
        int i;
        int j;
        int piv;
        int sw;
        int tmp;
        int c;
        int best_c;
        int tour[0:MAX_CITIES];
        int best[0:MAX_CITIES];
        bit found;
        tour_word_t tw;
        if (w.mode == MODE_LOAD)
        begin
            weight_mirror[w.from_city][w.to_city] = w.weight;
            return;
        end
        n = eff_cities(cfg_city_count);
        s = int'(cfg_start_city);
        if (s < 1)
            s = 1;
        if (s > n)
            s = n;
        tour[0] = s;
        tour[n] = s;
        j = 1;
        for (i = 1; i < n; i++)
        begin
            if (j == s)
                j++;
            tour[i] = j;
            j++;
        end
        best = tour;
        best_c = tour_length(tour, n);
        piv = 0;
        sw = 0;
        while (1'b1)
        begin
            // Find the rightmost ascent among the inner cities.
            found = 1'b0;
            for (i = 1; i + 1 < n; i++)
            begin
                if (tour[i] < tour[i+1])
                begin
                    piv = i;
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            for (j = piv + 1; j < n; j++)
            begin
                if (tour[piv] < tour[j])
                    sw = j;
            end
            tmp = tour[piv];
            tour[piv] = tour[sw];
            tour[sw] = tmp;
            // Reverse the tail after the pivot.
            i = piv + 1;
            j = n - 1;
            while (i < j)
            begin
                tmp = tour[i];
                tour[i] = tour[j];
                tour[j] = tmp;
                i++;
                j--;
            end
            c = tour_length(tour, n);
            if (c < best_c)
            begin
                best_c = c;
                best = tour;
            end
        end
        for (i = 0; i <= n; i++)
        begin
            tw.city = CITY_W'(best[i]);
            tw.cost = COST_W'(best_c);
            tw.last = (i == n);
            tour_words_due.push_back(tw);
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Queue one input word with a freshly drawn lead-in gap.
    task automatic push_word(input logic m, input int row, input int col, input int w);
        word_t item;
        item.mode = m;
        item.from_city = INDEX_W'(row);
        item.to_city = INDEX_W'(col);
        item.weight = WEIGHT_W'(w);
        item.gap = $urandom_range(0, send_gap_max);
        if (m == MODE_LOAD)
            loaded[row][col] = 1'b1;
        word_queue.push_back(item);
        words_queued++;
    endtask

    // Queue a search, first loading any edge of the active cities that was never written.
    task automatic queue_search();
        int a;
        int b;
        for (a = 0; a < stim_cities; a++)
        begin
            for (b = 0; b < stim_cities; b++)
            begin
                if (a != b && !loaded[a][b])
                    push_word(MODE_LOAD, a, b, $urandom_range(0, 65535));
            end
        end
        push_word(MODE_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 65535));
    endtask

    // Give every edge among the active cities the same weight.
    task automatic fill_matrix(input int value);
        int a;
        int b;
        for (a = 0; a < stim_cities; a++)
        begin
            for (b = 0; b < stim_cities; b++)
            begin
                if (a != b)
                    push_word(MODE_LOAD, a, b, value);
            end
        end
    endtask

    task automatic wait_drained();
        while (words_accepted != words_queued || tour_words_due.size() != 0)
            @(negedge clk);
    endtask

    // One write: setup phase, access phase, then the bus returns to idle.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_tour_config(input int count, input int start);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(ADDR_CITY_COUNT, count);
        write_register(ADDR_START_CITY, start);
        stim_cities = eff_cities(CITY_W'(count));
    endtask

    // Sender: offers the head of the queue after its gap and holds it until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            word_taken = 1'b0;
            if (word_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (word_queue[0].gap > 0)
            begin
                word_queue[0].gap = word_queue[0].gap - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                cur_word = word_queue.pop_front();
                mode <= cur_word.mode;
                from_city <= cur_word.from_city;
                to_city <= cur_word.to_city;
                weight <= cur_word.weight;
                in_valid <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_count = HOLD_CYCLES;
        end
        if (hold_count > 0)
        begin
            hold_count--;
            long_hold <= 1'b1;
        end
        else
        begin
            long_hold <= 1'b0;
        end
    end

    // Receiver: stalls a random number of cycles after each tour word, and during a long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (tour_taken)
            begin
                tour_taken = 1'b0;
                stall_left = $urandom_range(0, recv_stall_max);
            end
            if (long_hold || stall_left > 0)
            begin
                out_ready <= 1'b0;
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on accepted words, checks tour words, tracks register writes.
    always @(posedge clk)
    begin
        tour_word_t due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                word_taken = 1'b1;
                words_accepted++;
                if (cur_word.mode == MODE_RUN)
                    search_count++;
                predict_best_tour(cur_word);
            end
            if (out_valid && out_ready)
            begin
                tour_taken = 1'b1;
                if (tour_words_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected tour word city %0d cost %0d last %0b",
                                              tour_city, tour_cost, last));
                end
                else
                begin
                    due = tour_words_due.pop_front();
                    tour_words_checked++;
                    if (tour_city !== due.city)
                        report_mismatch($sformatf("tour_city %0d, want %0d",
                                                  tour_city, due.city));
                    if (tour_cost !== due.cost)
                        report_mismatch($sformatf("tour_cost %0d, want %0d",
                                                  tour_cost, due.cost));
                    if (last !== due.last)
                        report_mismatch($sformatf("last %0b, want %0b", last, due.last));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_CITY_COUNT)
                    cfg_city_count = pwdata[CITY_W-1:0];
                else if (paddr == ADDR_START_CITY)
                    cfg_start_city = pwdata[CITY_W-1:0];
            end
        end
    end

    // Stimulus: directed checks first, then random phases over several city settings.
    initial
    begin
        int ph_count[9];
        int ph_start[9];
        int ph_items[9];
        int ph_runs[9];
        int p;
        int k;
        int runs_left;
        int row;
        int col;
        int w;
        ph_count = '{4, 5, 3, 6, 7, 15, 8, 4, 5};
        ph_start = '{4, 15, 0, 2, 7, 8, 1, 3, 1};
        ph_items = '{28, 28, 26, 24, 14, 10, 10, 26, 26};
        ph_runs  = '{8, 6, 10, 4, 2, 1, 1, 8, 6};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Three cities with one clearly cheap direction around the loop.
        set_tour_config(3, 1);
        push_word(MODE_LOAD, 7, 7, 65535);
        push_word(MODE_LOAD, 0, 0, 0);
        push_word(MODE_LOAD, 0, 1, 1);
        push_word(MODE_LOAD, 1, 2, 1);
        push_word(MODE_LOAD, 2, 0, 1);
        push_word(MODE_LOAD, 0, 2, 65535);
        push_word(MODE_LOAD, 2, 1, 65535);
        push_word(MODE_LOAD, 1, 0, 65535);
        queue_search();
        // Every tour ties, so the first one must be kept.
        fill_matrix(500);
        queue_search();
        // Heaviest weights on every edge.
        fill_matrix(65535);
        queue_search();
        // City count below the minimum and start city zero.
        set_tour_config(2, 0);
        queue_search();
        // Start city beyond the city count.
        set_tour_config(0, 9);
        queue_search();

        // Receiver holds off while the sender keeps offering searches and loads back to back.
        set_tour_config(3, 2);
        send_gap_max = 0;
        recv_stall_max = 0;
        @(posedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        for (k = 0; k < 16; k++)
        begin
            if (k % 4 == 3)
                push_word(MODE_LOAD, $urandom_range(0, 2), $urandom_range(0, 2),
                          $urandom_range(0, 65535));
            else
                queue_search();
        end

        // Random phases: weight loads biased toward the active cities, mixed with searches.
        for (p = 0; p < 9; p++)
        begin
            set_tour_config(ph_count[p], ph_start[p]);
            send_gap_max = (p % 3 == 1) ? 0 : 9;
            recv_stall_max = (p % 3 == 2) ? 0 : 9;
            runs_left = ph_runs[p];
            for (k = 0; k < ph_items[p]; k++)
            begin
                // Sender waits here until every pending tour word has come back.
                if (p == 3 && k == ph_items[p] / 2)
                    wait_drained();
                if (runs_left > 0 && $urandom_range(0, 3) == 0)
                begin
                    queue_search();
                    runs_left--;
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        row = $urandom_range(0, 7);
                        col = $urandom_range(0, 7);
                    end
                    else
                    begin
                        row = $urandom_range(0, stim_cities - 1);
                        col = $urandom_range(0, stim_cities - 1);
                    end
                    case ($urandom_range(0, 3))
                        0: w = $urandom_range(0, 1) ? 65535 : 0;
                        1: w = $urandom_range(0, 3);
                        default: w = $urandom_range(0, 65535);
                    endcase
                    push_word(MODE_LOAD, row, col, w);
                end
            end
            if (runs_left == ph_runs[p])
                queue_search();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Drove %0d words including %0d searches over 3 to %0d cities,",
                 words_accepted, search_count, MAX_CITIES);
        $display("with clamped settings, ties and stalls; %0d tour words checked.",
                 tour_words_checked);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tse_pkg.sv
sv/tse_controller.sv
sv/tse_datapath.sv
sv/tsp_exhaustive_search_unit.sv
dv/tsp_exhaustive_search_unit_tb.sv
